@@ sv/chip8ie_pkg.sv @@
// Shared types and constants for the CHIP-8 instruction executor.
`default_nettype none

package chip8ie_pkg;

    localparam int NUM_REGS = 16;

    localparam logic [3:0] C_SYS  = 4'h0;
    localparam logic [3:0] C_JP   = 4'h1;
    localparam logic [3:0] C_CALL = 4'h2;
    localparam logic [3:0] C_SE   = 4'h3;
    localparam logic [3:0] C_SNE  = 4'h4;
    localparam logic [3:0] C_SER  = 4'h5;
    localparam logic [3:0] C_LD   = 4'h6;
    localparam logic [3:0] C_ADD  = 4'h7;
    localparam logic [3:0] C_SNER = 4'h9;
    localparam logic [3:0] C_LDI  = 4'hA;
    localparam logic [3:0] C_JPV0 = 4'hB;
    localparam logic [3:0] C_RND  = 4'hC;

    localparam logic [15:0] W_CLS = 16'h00E0;
    localparam logic [15:0] W_RET = 16'h00EE;

    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [11:0] PC_STEP  = 12'd2;

    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [7:0] data;
    } t_rf_wr;

endpackage

`default_nettype wire

@@ sv/chip8ie_regfile.sv @@
// General register file: synchronous memory with reset-valid bits and write forwarding.
`default_nettype none

module chip8ie_regfile
    import chip8ie_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rd_en,
    input  wire logic [3:0] i_rd_addr_a,
    input  wire logic [3:0] i_rd_addr_b,
    input  wire t_rf_wr     i_wr,
    output logic [7:0]      o_rd_data_a,
    output logic [7:0]      o_rd_data_b
);

    localparam logic [1:0] SRC_MEM  = 2'd0;
    localparam logic [1:0] SRC_ZERO = 2'd1;
    localparam logic [1:0] SRC_FWD  = 2'd2;

    logic [7:0]          r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [7:0]          r_q_a;
    logic [7:0]          r_q_b;
    logic [1:0]          r_src_a;
    logic [1:0]          r_src_b;
    logic [7:0]          r_fwd_data;
    logic [1:0]          n_src_a;
    logic [1:0]          n_src_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q_a <= r_mem[i_rd_addr_a];
            r_q_b <= r_mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_comb begin
        if (i_wr.en && (i_wr.addr == i_rd_addr_a)) begin
            n_src_a = SRC_FWD;
        end else if (!r_valid[i_rd_addr_a]) begin
            n_src_a = SRC_ZERO;
        end else begin
            n_src_a = SRC_MEM;
        end
        if (i_wr.en && (i_wr.addr == i_rd_addr_b)) begin
            n_src_b = SRC_FWD;
        end else if (!r_valid[i_rd_addr_b]) begin
            n_src_b = SRC_ZERO;
        end else begin
            n_src_b = SRC_MEM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_src_a    <= n_src_a;
            r_src_b    <= n_src_b;
            r_fwd_data <= i_wr.data;
        end
    end

    always_comb begin
        case (r_src_a)
            SRC_FWD:  o_rd_data_a = r_fwd_data;
            SRC_ZERO: o_rd_data_a = 8'd0;
            default:  o_rd_data_a = r_q_a;
        endcase
        case (r_src_b)
            SRC_FWD:  o_rd_data_b = r_fwd_data;
            SRC_ZERO: o_rd_data_b = 8'd0;
            default:  o_rd_data_b = r_q_b;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/chip8ie_stack.sv @@
// Return address stack: synchronous memory with write forwarding.
`default_nettype none

module chip8ie_stack
    import chip8ie_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [11:0]   i_wr_data,
    output logic [11:0]        o_rd_data
);

    logic [11:0] r_mem [DEPTH];
    logic [11:0] r_q;
    logic        r_fwd;
    logic [11:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

`default_nettype wire

@@ sv/chip8_instruction_executor.sv @@
// Top level of the CHIP-8 instruction executor: request handshakes, execute stage, output register.
`default_nettype none

// Takes one instruction request per cycle while the output is not stalled and returns one
// result per request, in order. An accepted request has its memory reads registered along
// with it into the execute stage, executes there and is then registered into the output
// register; sustained throughput is one instruction per cycle without output stalls. The rate
// is set by the single read-modify-write pass through the register file and return stack
// memories, whose registered reads are covered by forwarding from the write of the instruction
// ahead. The stack pointer advances at acceptance, so return addresses are read at the right
// entry even when calls and returns follow each other directly. No clearing pass is needed
// after reset; the block accepts requests in the first cycle after reset is released.

module chip8_instruction_executor
    import chip8ie_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_instruction_word,
    input  wire logic [7:0]  i_random_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [11:0]      o_next_pc,
    output logic             o_clear_display,
    output logic             o_unsupported,
    output logic [11:0]      o_index_value
);

    localparam int SpW = $clog2(STACK_DEPTH);
    localparam logic [SpW-1:0] SP_LAST = SpW'(STACK_DEPTH - 1);

    logic           accept;
    logic           advance;
    logic           commit;

    logic           r_s1_v;
    logic [15:0]    r_word;
    logic [7:0]     r_rnd;
    logic [SpW-1:0] r_saddr;
    logic [SpW-1:0] r_sp;
    logic [SpW-1:0] n_sp;
    logic [SpW-1:0] sp_inc;
    logic [SpW-1:0] sp_dec;
    logic [3:0]     in_cls;
    logic [3:0]     rd_addr_b;

    logic [11:0]    r_pc;
    logic [11:0]    r_index;
    logic [11:0]    n_pc;
    logic [11:0]    n_index;

    logic           r_out_v;
    logic [11:0]    r_out_pc;
    logic           r_out_clr;
    logic           r_out_uns;
    logic [11:0]    r_out_index;

    logic [3:0]     cls;
    logic [7:0]     kk;
    logic [11:0]    nnn;
    logic [11:0]    pc_adv;
    logic [7:0]     vx;
    logic [7:0]     vy;
    logic [11:0]    stk_data;
    logic           skip;
    logic           clr;
    logic           uns;
    logic           stk_we;
    t_rf_wr         rf_wr;
    t_rf_wr         rf_wr_gated;

    assign advance    = !r_out_v || !i_out_stall;
    assign o_in_stall = r_s1_v && !advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign commit     = r_s1_v && advance;

    assign in_cls    = i_instruction_word[15:12];
    assign rd_addr_b = (in_cls == C_JPV0) ? 4'd0 : i_instruction_word[7:4];
    assign sp_inc    = (r_sp == SP_LAST) ? '0 : r_sp + SpW'(1);
    assign sp_dec    = (r_sp == '0) ? SP_LAST : r_sp - SpW'(1);

    always_comb begin
        n_sp = r_sp;
        if (in_cls == C_CALL) begin
            n_sp = sp_inc;
        end else if (i_instruction_word == W_RET) begin
            n_sp = sp_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (accept) begin
            r_sp <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (advance) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word  <= i_instruction_word;
            r_rnd   <= i_random_byte;
            r_saddr <= (in_cls == C_CALL) ? sp_inc : r_sp;
        end
    end

    chip8ie_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (i_instruction_word[11:8]),
        .i_rd_addr_b (rd_addr_b),
        .i_wr        (rf_wr_gated),
        .o_rd_data_a (vx),
        .o_rd_data_b (vy)
    );

    chip8ie_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (SpW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_sp),
        .i_wr_en   (stk_we && commit),
        .i_wr_addr (r_saddr),
        .i_wr_data (pc_adv),
        .o_rd_data (stk_data)
    );

    assign cls    = r_word[15:12];
    assign kk     = r_word[7:0];
    assign nnn    = r_word[11:0];
    assign pc_adv = r_pc + PC_STEP;

    always_comb begin
        n_pc       = pc_adv;
        n_index    = r_index;
        skip       = 1'b0;
        clr        = 1'b0;
        uns        = 1'b0;
        stk_we     = 1'b0;
        rf_wr.en   = 1'b0;
        rf_wr.addr = r_word[11:8];
        rf_wr.data = kk;
        case (cls)
            C_SYS: begin
                if (r_word == W_CLS) begin
                    clr = 1'b1;
                end else if (r_word == W_RET) begin
                    n_pc = stk_data;
                end else begin
                    uns = 1'b1;
                end
            end
            C_JP: begin
                n_pc = nnn;
            end
            C_CALL: begin
                stk_we = 1'b1;
                n_pc   = nnn;
            end
            C_SE: begin
                skip = (vx == kk);
            end
            C_SNE: begin
                skip = (vx != kk);
            end
            C_SER: begin
                skip = (vx == vy);
            end
            C_LD: begin
                rf_wr.en = 1'b1;
            end
            C_ADD: begin
                rf_wr.en   = 1'b1;
                rf_wr.data = vx + kk;
            end
            C_SNER: begin
                skip = (vx != vy);
            end
            C_LDI: begin
                n_index = nnn;
            end
            C_JPV0: begin
                n_pc = nnn + {4'd0, vy};
            end
            C_RND: begin
                rf_wr.en   = 1'b1;
                rf_wr.data = r_rnd & kk;
            end
            default: begin
                uns = 1'b1;
            end
        endcase
        if (skip) begin
            n_pc = pc_adv + PC_STEP;
        end
    end

    always_comb begin
        rf_wr_gated    = rf_wr;
        rf_wr_gated.en = rf_wr.en && commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_RESET;
            r_index <= 12'd0;
        end else if (commit) begin
            r_pc    <= n_pc;
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_pc    <= n_pc;
            r_out_clr   <= clr;
            r_out_uns   <= uns;
            r_out_index <= n_index;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_next_pc       = r_out_pc;
    assign o_clear_display = r_out_clr;
    assign o_unsupported   = r_out_uns;
    assign o_index_value   = r_out_index;

`ifndef SYNTHESIS
    a_pc_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_pc == PC_RESET) && (r_sp == '0) && !r_s1_v && !r_out_v)
        else $error("Reset did not restore the program counter and pipeline.");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_LAST)
        else $error("Stack pointer left its range.");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !advance) |=> r_s1_v && $stable(r_word) && $stable(r_pc))
        else $error("Execute stage changed while blocked.");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_s1_v))
        else $error("Output became valid without a request in the execute stage.");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |-> !rf_wr_gated.en)
        else $error("Register file written without a committing request.");
`endif

endmodule

`default_nettype wire
